@@ rtl/humidity_to_pointer_angle_unit_defines.svh @@
// Assertion macros shared by the humidity to pointer angle RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef HUMIDITY_TO_POINTER_ANGLE_UNIT_DEFINES_SVH
`define HUMIDITY_TO_POINTER_ANGLE_UNIT_DEFINES_SVH

// same-cycle implication, disabled during reset
`define HTPA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("htpa assertion failed");

// next-cycle implication, disabled during reset
`define HTPA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("htpa assertion failed");

`endif

@@ rtl/htpa_pkg.sv @@
// Package for the humidity to pointer angle unit: tables, queue sizes, work item type.
// No dependencies.
`default_nettype none

package htpa_pkg;

    localparam int MAX_POINTS = 16;
    localparam int NUM_ROWS   = 5;
    localparam int ROW_W      = 3;
    localparam int HUM_W      = 7;
    localparam int ANG_W      = 8;
    localparam int DIV_STEPS  = 8;
    localparam int MID_DEPTH  = 4;
    localparam int OUT_DEPTH  = 16;

    localparam logic [ROW_W-1:0] ROW_MAX   = 3'd4;
    localparam logic [ROW_W-1:0] ROW_YEAR  = 3'd0;
    localparam logic [ANG_W-1:0] ANGLE_MAX = 8'd180;

    // breakpoints per season row, entries past the ninth are zero
    localparam logic [HUM_W-1:0] BP_TABLE [NUM_ROWS][MAX_POINTS] = '{
        '{7'd13, 7'd40, 7'd48, 7'd66, 7'd81, 7'd89, 7'd93, 7'd96, 7'd100,
          7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0},
        '{7'd13, 7'd32, 7'd37, 7'd50, 7'd70, 7'd86, 7'd93, 7'd96, 7'd100,
          7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0},
        '{7'd13, 7'd37, 7'd42, 7'd53, 7'd69, 7'd83, 7'd93, 7'd96, 7'd100,
          7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0},
        '{7'd13, 7'd49, 7'd60, 7'd75, 7'd83, 7'd93, 7'd95, 7'd97, 7'd100,
          7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0},
        '{7'd13, 7'd64, 7'd69, 7'd79, 7'd86, 7'd93, 7'd96, 7'd98, 7'd100,
          7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0}
    };

    localparam logic [ANG_W-1:0] ANG_TABLE [MAX_POINTS] = '{
        8'd0, 8'd9, 8'd19, 8'd47, 8'd95, 8'd142, 8'd171, 8'd180, 8'd180,
        8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0
    };

    // classified reading, handed from front to back
    typedef struct packed {
        logic             clipped;  // below first breakpoint
        logic             above;    // past last breakpoint
        logic [HUM_W-1:0] hd;       // reading minus lower breakpoint
        logic [ANG_W-1:0] da;       // angle span of segment
        logic [HUM_W-1:0] dw;       // breakpoint span, never zero
        logic [ANG_W-1:0] a0;       // lower angle
    } t_work;

endpackage

`default_nettype wire

@@ rtl/htpa_fifo.sv @@
// Small synchronous FIFO with registered storage and head read-through.
// No dependencies.
`default_nettype none

module htpa_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_wr,
    input  wire logic [WIDTH-1:0] i_wdata,
    output logic                  o_full,
    input  wire logic             i_rd,
    output logic      [WIDTH-1:0] o_rdata,
    output logic                  o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wptr, n_wptr;
    logic [AW-1:0]    r_rptr, n_rptr;
    logic [CW-1:0]    r_count, n_count;
    logic             wr_en, rd_en;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_rdata = r_mem[r_rptr];
    assign wr_en   = i_wr && !o_full;
    assign rd_en   = i_rd && !o_empty;

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        if (wr_en) begin
            n_wptr = (r_wptr == AW'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
        end
        if (rd_en) begin
            n_rptr = (r_rptr == AW'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
        end
        n_count = r_count + CW'(wr_en) - CW'(rd_en);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wptr] <= i_wdata;
        end
    end

endmodule

`default_nettype wire

@@ rtl/htpa_front.sv @@
// Front end: segment search over the breakpoint row, output register with handshake.
// Depends on htpa_pkg.
`default_nettype none

module htpa_front
    import htpa_pkg::*;
#(
    parameter int NUM_BREAKPOINTS = 9
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_ready,
    input  wire logic [HUM_W-1:0] i_humidity,
    input  wire logic [ROW_W-1:0] i_season,
    output logic                  o_valid,
    input  wire logic             i_ready,
    output t_work                 o_work
);

    logic [ROW_W-1:0] row;
    logic [HUM_W-1:0] row_bp [MAX_POINTS];
    logic             found;
    logic             degen;
    logic [HUM_W-1:0] w0, w1;
    logic [ANG_W-1:0] a0, a1;
    t_work            work;
    logic             r_valid;
    t_work            r_work;

    // unused season codes fall back to the whole-year row
    assign row    = (i_season <= ROW_MAX) ? i_season : ROW_YEAR;
    assign row_bp = BP_TABLE[row];

    always_comb begin
        found = 1'b0;
        w0    = '0;
        w1    = '0;
        a0    = '0;
        a1    = '0;
        for (int i = 0; i < NUM_BREAKPOINTS - 1; i++) begin
            if (!found && (i_humidity <= row_bp[i + 1])) begin
                found = 1'b1;
                w0    = row_bp[i];
                w1    = row_bp[i + 1];
                a0    = ANG_TABLE[i];
                a1    = ANG_TABLE[i + 1];
            end
        end
        degen        = (w1 <= w0);
        work.clipped = (i_humidity < row_bp[0]);
        work.above   = !found;
        if (degen || !found) begin
            // zero-width segment lands on its upper angle; with no segment found that angle is zero
            work.hd = '0;
            work.da = '0;
            work.dw = HUM_W'(1);
            work.a0 = a1;
        end else begin
            work.hd = i_humidity - w0;
            work.da = a1 - a0;
            work.dw = w1 - w0;
            work.a0 = a0;
        end
    end

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_work  = r_work;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_work <= work;
        end
    end

endmodule

`default_nettype wire

@@ rtl/htpa_back.sv @@
// Back end: multiply, eight-step restoring divide pipeline, rounding and clamp.
// Depends on htpa_pkg. Free-running; the caller bounds issue by output space.
`default_nettype none

module htpa_back
    import htpa_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    input  wire t_work            i_work,
    output logic                  o_valid,
    output logic      [ANG_W-1:0] o_angle,
    output logic                  o_clipped
);

    localparam int PROD_W = HUM_W + ANG_W;

    typedef struct packed {
        logic              clipped;
        logic              above;
        logic [PROD_W-1:0] rem;
        logic [ANG_W-1:0]  q;
        logic [HUM_W-1:0]  dw;
        logic [ANG_W-1:0]  a0;
    } t_div;

    t_div                r_div [DIV_STEPS + 1];
    t_div                n_div [DIV_STEPS + 1];
    logic                r_vld [DIV_STEPS + 1];
    logic [PROD_W-1:0]   sub   [DIV_STEPS + 1];
    logic                adj;
    logic signed [10:0]  base;
    logic [ANG_W-1:0]    angle;
    logic                r_ovld;
    logic [ANG_W-1:0]    r_angle;
    logic                r_clipped;

    // stage 0: product (h - w0) * da; stages 1..8: one quotient bit each
    always_comb begin
        n_div[0].clipped = i_work.clipped;
        n_div[0].above   = i_work.above;
        n_div[0].rem     = PROD_W'(i_work.hd) * PROD_W'(i_work.da);
        n_div[0].q       = '0;
        n_div[0].dw      = i_work.dw;
        n_div[0].a0      = i_work.a0;
        sub[0]           = '0;
        for (int k = 1; k <= DIV_STEPS; k++) begin
            n_div[k] = r_div[k - 1];
            sub[k]   = PROD_W'(r_div[k - 1].dw) << (DIV_STEPS - k);
            if (r_div[k - 1].rem >= sub[k]) begin
                n_div[k].rem                = r_div[k - 1].rem - sub[k];
                n_div[k].q[DIV_STEPS - k]   = 1'b1;
            end
        end
    end

    // floor(180.5 - a0 - q - rem/dw): drop one more when the fraction exceeds one half
    always_comb begin
        adj  = ({r_div[DIV_STEPS].rem, 1'b0} > (PROD_W + 1)'(r_div[DIV_STEPS].dw));
        base = 11'sd180 - $signed({3'b000, r_div[DIV_STEPS].a0})
                        - $signed({3'b000, r_div[DIV_STEPS].q})
                        - $signed({10'd0, adj});
        if (r_div[DIV_STEPS].clipped) begin
            angle = ANGLE_MAX;
        end else if (r_div[DIV_STEPS].above || base < 0) begin
            angle = '0;
        end else begin
            angle = base[ANG_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= DIV_STEPS; k++) begin
                r_vld[k] <= 1'b0;
            end
            r_ovld <= 1'b0;
        end else begin
            r_vld[0] <= i_valid;
            for (int k = 1; k <= DIV_STEPS; k++) begin
                r_vld[k] <= r_vld[k - 1];
            end
            r_ovld <= r_vld[DIV_STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k <= DIV_STEPS; k++) begin
            r_div[k] <= n_div[k];
        end
        r_angle   <= angle;
        r_clipped <= r_div[DIV_STEPS].clipped;
    end

    assign o_valid   = r_ovld;
    assign o_angle   = r_angle;
    assign o_clipped = r_clipped;

endmodule

`default_nettype wire

@@ rtl/humidity_to_pointer_angle_unit.sv @@
// An accepted reading passes front register, mid queue, back end and output queue,
// whose head drives the result ports. One reading per cycle is sustained while
// results are popped; the output queue (16 entries) and issue credits cover the
// multiply/divide pipeline. Reset, synchronous and active low, clears queues and
// pipeline valids, sets credits full and season to the whole-year row. No clearing
// pass. Depends on htpa_pkg, htpa_front, htpa_fifo, htpa_back and the defines header.
`default_nettype none
`include "humidity_to_pointer_angle_unit_defines.svh"

module humidity_to_pointer_angle_unit
    import htpa_pkg::*;
#(
    parameter int NUM_BREAKPOINTS = 9
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             push,
    output logic                  full,
    input  wire logic [HUM_W-1:0] i_humidity,
    output logic                  empty,
    input  wire logic             pop,
    output logic      [ANG_W-1:0] o_angle,
    output logic                  o_clipped,
    input  wire logic             i_cfg_valid,
    output logic                  o_cfg_ready,
    input  wire logic [ROW_W-1:0] i_cfg_data
);

    localparam int WORK_W   = $bits(t_work);
    localparam int RES_W    = ANG_W + 1;
    localparam int CREDIT_W = $clog2(OUT_DEPTH + 1);

    logic [ROW_W-1:0]    r_season;
    logic                front_ready;
    logic                front_valid;
    t_work               front_work;
    logic                mid_full;
    logic                mid_empty;
    logic [WORK_W-1:0]   mid_head;
    logic                issue;
    logic                back_valid;
    logic [ANG_W-1:0]    back_angle;
    logic                back_clipped;
    logic                out_full;
    logic [RES_W-1:0]    out_head;
    logic                pop_acc;
    logic [CREDIT_W-1:0] r_credit, n_credit;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_season <= ROW_YEAR;
        end else if (i_cfg_valid) begin
            r_season <= i_cfg_data;
        end
    end

    htpa_front #(
        .NUM_BREAKPOINTS (NUM_BREAKPOINTS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (push),
        .o_ready    (front_ready),
        .i_humidity (i_humidity),
        .i_season   (r_season),
        .o_valid    (front_valid),
        .i_ready    (!mid_full),
        .o_work     (front_work)
    );

    assign full = !front_ready;

    htpa_fifo #(
        .WIDTH (WORK_W),
        .DEPTH (MID_DEPTH)
    ) u_mid_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (front_valid),
        .i_wdata (front_work),
        .o_full  (mid_full),
        .i_rd    (issue),
        .o_rdata (mid_head),
        .o_empty (mid_empty)
    );

    // a transaction enters the back end only with an output slot reserved for it
    assign issue    = !mid_empty && (r_credit != '0);
    assign pop_acc  = pop && !empty;
    assign n_credit = r_credit - CREDIT_W'(issue) + CREDIT_W'(pop_acc);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_credit <= CREDIT_W'(OUT_DEPTH);
        end else begin
            r_credit <= n_credit;
        end
    end

    htpa_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (issue),
        .i_work    (t_work'(mid_head)),
        .o_valid   (back_valid),
        .o_angle   (back_angle),
        .o_clipped (back_clipped)
    );

    htpa_fifo #(
        .WIDTH (RES_W),
        .DEPTH (OUT_DEPTH)
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (back_valid),
        .i_wdata ({back_angle, back_clipped}),
        .o_full  (out_full),
        .i_rd    (pop),
        .o_rdata (out_head),
        .o_empty (empty)
    );

    assign o_angle   = out_head[RES_W-1:1];
    assign o_clipped = out_head[0];

    `HTPA_ASSERT_IMP(a_out_no_overflow, i_clk, i_rst_n, back_valid, !out_full)
    `HTPA_ASSERT_IMP(a_clipped_at_max, i_clk, i_rst_n, !empty && o_clipped,
                     o_angle == ANGLE_MAX)
    `HTPA_ASSERT_IMP(a_angle_range, i_clk, i_rst_n, !empty, o_angle <= ANGLE_MAX)
    `HTPA_ASSERT_IMP(a_credit_bound, i_clk, i_rst_n, 1'b1,
                     r_credit <= CREDIT_W'(OUT_DEPTH))
    `HTPA_ASSERT_NXT(a_credit_take, i_clk, i_rst_n, issue && !pop_acc,
                     r_credit == $past(r_credit) - 1'b1)

endmodule

`default_nettype wire
